[sv/servo_reply_frame_receiver_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the servo reply frame receiver
// Shared concurrent assertion forms, sampled on clk_i.
// ----------------------------------------------------------------------------
`ifndef SERVO_REPLY_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SERVO_REPLY_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Property checked only while out of reset
`define SRFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked at every edge, reset included
`define SRFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/srfr_pkg.sv]
// ----------------------------------------------------------------------------
// srfr_pkg
// Types and constants shared by the frame receiver controller and datapath.
// ----------------------------------------------------------------------------
package srfr_pkg;

  localparam int BufferBytesDef = 16;

  localparam logic [7:0] HeaderValueReset = 8'd85;
  localparam logic [3:0] MaxLengthReset   = 4'd8;
  localparam logic [3:0] MinLength        = 4'd2;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_VALUE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LENGTH   = 2'd1;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic take_item;
    logic clr_index;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_start;
    logic out_free;
    logic last_slot;
  } ctrl_status_t;

endpackage

[sv/srfr_ctrl.sv]
// ----------------------------------------------------------------------------
// srfr_ctrl
// Sequencer: takes requests while idle, then walks the frame store out.
// ----------------------------------------------------------------------------
`include "servo_reply_frame_receiver_unit_defines.svh"

module srfr_ctrl import srfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_item = in_valid_i;
        if (in_valid_i && status_i.emit_start) begin
          cmd_o.clr_index = 1'b1;
          state_d         = ST_FETCH;
        end
      end
      // store read data lands in the cycle after the index settles
      ST_FETCH: begin
        state_d = ST_SEND;
      end
      ST_SEND: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = status_i.last_slot ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `SRFR_ASSERT(a_load_needs_room, cmd_o.load_out |-> status_i.out_free, "load into busy output")
  `SRFR_ASSERT(a_fetch_then_send, (state_q == ST_FETCH) |=> (state_q == ST_SEND), "fetch not followed by send")
  `SRFR_ASSERT(a_emit_enters_fetch, (cmd_o.take_item && status_i.emit_start) |=> (state_q == ST_FETCH), "frame completion did not start emission")

endmodule

[sv/srfr_datapath.sv]
// ----------------------------------------------------------------------------
// srfr_datapath
// Header hunt, length check, frame store, pending mark and output register.
// ----------------------------------------------------------------------------
`include "servo_reply_frame_receiver_unit_defines.svh"

module srfr_datapath import srfr_pkg::*; #(
  parameter int BUFFER_BYTES = BufferBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               kind_i,
  input  logic [7:0]         rx_byte_i,
  input  ctrl_cmd_t          cmd_i,
  output ctrl_status_t       status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         frame_byte_o,
  output logic [3:0]         byte_index_o,
  output logic               last_byte_o
);

  localparam int AddrW = $clog2(BUFFER_BYTES);
  localparam logic [3:0] MaxCap   = 4'(BUFFER_BYTES - 2);
  localparam logic [4:0] DepthLim = 5'(BUFFER_BYTES);

  logic [7:0] header_value_q;
  logic [3:0] max_length_q;

  logic       in_frame_q, in_frame_d;
  logic       header_seen_q, header_seen_d;
  logic [3:0] frame_length_q, frame_length_d;
  logic [3:0] byte_count_q, byte_count_d;
  logic       frame_pending_q;

  logic [7:0] store_mem [BUFFER_BYTES];
  logic [7:0] rd_data_q;
  logic [3:0] emit_idx_q;

  logic       out_valid_q;
  logic [7:0] frame_byte_q;
  logic [3:0] byte_index_q;
  logic       last_byte_q;

  logic [3:0] eff_max;
  logic       opened;
  logic [3:0] slot_idx;
  logic       store_we;
  logic       complete;
  logic       is_byte;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_value_q <= HeaderValueReset;
      max_length_q   <= MaxLengthReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEADER_VALUE: header_value_q <= cfg_data_i;
        CFG_MAX_LENGTH:   max_length_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign eff_max = (max_length_q > MaxCap) ? MaxCap : max_length_q;
  assign is_byte = (kind_i == KIND_BYTE);

  // receive step for one byte
  always_comb begin
    opened         = in_frame_q;
    header_seen_d  = header_seen_q;
    byte_count_d   = byte_count_q;
    frame_length_d = frame_length_q;
    in_frame_d     = in_frame_q;
    complete       = 1'b0;
    if (!in_frame_q) begin
      if (rx_byte_i == header_value_q) begin
        if (header_seen_q) begin
          header_seen_d = 1'b0;
          opened        = 1'b1;
          byte_count_d  = 4'd1;
        end else begin
          header_seen_d = 1'b1;
        end
      end else begin
        header_seen_d = 1'b0;
        byte_count_d  = 4'd0;
      end
    end
    slot_idx   = byte_count_d;
    in_frame_d = opened;
    if (opened) begin
      if (slot_idx == 4'd2) begin
        if ((rx_byte_i < {4'd0, MinLength}) || (rx_byte_i > {4'd0, eff_max})) begin
          frame_length_d = MinLength;
          in_frame_d     = 1'b0;
        end else begin
          frame_length_d = rx_byte_i[3:0];
        end
      end
      complete = (({1'b0, slot_idx} + 5'd1) == ({1'b0, frame_length_d} + 5'd2));
      if (complete) begin
        in_frame_d = 1'b0;
      end
      byte_count_d = slot_idx + 4'd1;
    end
  end

  assign store_we = cmd_i.take_item && is_byte && opened
                    && ({1'b0, slot_idx} < DepthLim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q      <= 1'b0;
      header_seen_q   <= 1'b0;
      frame_length_q  <= MinLength;
      byte_count_q    <= 4'd0;
      frame_pending_q <= 1'b0;
    end else if (cmd_i.take_item) begin
      if (is_byte) begin
        in_frame_q     <= in_frame_d;
        header_seen_q  <= header_seen_d;
        frame_length_q <= frame_length_d;
        byte_count_q   <= byte_count_d;
        if (complete) begin
          frame_pending_q <= 1'b1;
        end
      end else begin
        frame_pending_q <= 1'b0;
      end
    end
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[slot_idx[AddrW-1:0]] <= rx_byte_i;
    end
    rd_data_q <= store_mem[emit_idx_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_idx_q <= 4'd0;
    end else if (cmd_i.clr_index) begin
      emit_idx_q <= 4'd0;
    end else if (cmd_i.load_out) begin
      emit_idx_q <= emit_idx_q + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      frame_byte_q <= (emit_idx_q == 4'd0) ? header_value_q : rd_data_q;
      byte_index_q <= emit_idx_q;
      last_byte_q  <= status_o.last_slot;
    end
  end

  assign status_o.emit_start = is_byte && complete && !frame_pending_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.last_slot  = (emit_idx_q == (frame_length_q + 4'd1));

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = frame_byte_q;
  assign byte_index_o = byte_index_q;
  assign last_byte_o  = last_byte_q;

  `SRFR_ASSERT(a_pending_during_emit, cmd_i.load_out |-> frame_pending_q, "emitting without pending mark")
  `SRFR_ASSERT(a_emit_in_range, cmd_i.load_out |-> (emit_idx_q <= (frame_length_q + 4'd1)), "emit index past frame end")
  `SRFR_ASSERT_ALWAYS(a_frame_count_nonzero, in_frame_q |-> (byte_count_q != 4'd0), "in frame with zero count")

endmodule

[sv/servo_reply_frame_receiver_unit.sv]
// After a frame's last byte is taken, the controller passes FETCH (store read) and
//   SEND, which loads the output register when free; each byte repeats this pair.
// One byte or release is taken per cycle while idle; none is taken during emission.
// Emission rate is set by the registered read port of the frame store.
// Reset (rst_ni, async, active low): hunting, nothing pending, config at defaults.
// ----------------------------------------------------------------------------
// servo_reply_frame_receiver_unit
// Double-header length-framed byte receiver with single pending frame hold.
// ----------------------------------------------------------------------------
module servo_reply_frame_receiver_unit import srfr_pkg::*; #(
  parameter int BUFFER_BYTES = BufferBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         frame_byte_o,
  output logic [3:0]         byte_index_o,
  output logic               last_byte_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  srfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srfr_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .kind_i       (kind_i),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .byte_index_o (byte_index_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

[dv/tb_servo_reply_frame_receiver_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_servo_reply_frame_receiver_unit
// Drives received bytes and releases into the frame receiver and checks every
// emitted frame byte against a cycle-free software model of the framing logic.
// ----------------------------------------------------------------------------
module tb_servo_reply_frame_receiver_unit;
  import srfr_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AFTER     = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int UNTYPED        = -1;
  localparam int N_ROWS         = 26;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] index;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    int         n_results;
  } stim_row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i   = CFG_HEADER_VALUE;
  logic [7:0]         cfg_data_i    = 8'h00;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic               kind_i        = KIND_BYTE;
  logic [7:0]         rx_byte_i     = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [7:0]         frame_byte_o;
  logic [3:0]         byte_index_o;
  logic               last_byte_o;
  int                 typed_results = UNTYPED;

  // model state
  logic [7:0] hdr_cfg = HeaderValueReset;
  logic [3:0] max_cfg = MaxLengthReset;
  logic       rx_in_frame = 1'b0;
  logic       rx_hdr_seen = 1'b0;
  logic [3:0] rx_len = MinLength;
  logic [3:0] rx_count = 4'd0;
  logic [7:0] rx_store [BufferBytesDef];
  logic       rx_pending = 1'b0;

  frame_byte_t due_frame_bytes [$];
  int          results_seen   = 0;
  int          mismatch_count = 0;
  int          idle_cycles    = 0;
  int          calm_in        = 0;
  logic [7:0]  cur_hdr        = HeaderValueReset;
  int          cur_lim        = 8;

  // rows typed with a count can be read straight off the framing rules
  stim_row_t directed_rows [N_ROWS] = '{
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h02, 0},
    '{KIND_BYTE,    8'h00, 4},
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h02, 0},
    '{KIND_BYTE,    8'hFF, 0},
    '{KIND_RELEASE, 8'hFF, 0},
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h09, 0},
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h3C, 0},
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h01, 0},
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h55, 0},
    '{KIND_BYTE,    8'h06, 0},
    '{KIND_BYTE,    8'h55, UNTYPED},
    '{KIND_BYTE,    8'hFF, UNTYPED},
    '{KIND_BYTE,    8'h00, UNTYPED},
    '{KIND_BYTE,    8'hAA, UNTYPED},
    '{KIND_BYTE,    8'h7E, 8},
    '{KIND_RELEASE, 8'h00, 0}
  };

  servo_reply_frame_receiver_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .byte_index_o (byte_index_o),
    .last_byte_o  (last_byte_o)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  function automatic void flag_mismatch(string what, int want, int got);
    mismatch_count++;
    $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
  endfunction

  // Advance the framing state by one request and queue the frame bytes it emits.
  function automatic int predict_frame_bytes(logic kind, logic [7:0] b);
    int          idx;
    int          nxt;
    int          lim;
    int          produced;
    frame_byte_t fb;
    produced = 0;
    if (kind == KIND_RELEASE) begin
      rx_pending = 1'b0;
      return 0;
    end
    if (!rx_in_frame) begin
      if (b == hdr_cfg) begin
        if (rx_hdr_seen) begin
          rx_hdr_seen = 1'b0;
          rx_in_frame = 1'b1;
          rx_count    = 4'd1;
        end else begin
          rx_hdr_seen = 1'b1;
        end
      end else begin
        rx_hdr_seen = 1'b0;
        rx_count    = 4'd0;
      end
    end
    if (rx_in_frame) begin
      idx = int'(rx_count);
      rx_store[idx] = b;
      if (idx == 2) begin
        lim = (int'(max_cfg) > BufferBytesDef - 2) ? BufferBytesDef - 2 : int'(max_cfg);
        if (int'(b) < int'(MinLength) || int'(b) > lim) begin
          rx_len      = MinLength;
          rx_in_frame = 1'b0;
        end else begin
          rx_len = b[3:0];
        end
      end
      nxt = idx + 1;
      if (nxt == int'(rx_len) + 2) begin
        if (!rx_pending) begin
          rx_pending = 1'b1;
          for (int k = 0; k < nxt; k++) begin
            fb.data  = (k == 0) ? hdr_cfg : rx_store[k];
            fb.index = 4'(k);
            fb.last  = (k + 1 == nxt);
            due_frame_bytes.push_back(fb);
            produced++;
          end
        end
        rx_in_frame = 1'b0;
      end
      rx_count = 4'(nxt);
    end
    return produced;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    frame_byte_t want;
    int          n_pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (due_frame_bytes.size() == 0) begin
          flag_mismatch("byte_index of a result with nothing due", -1, int'(byte_index_o));
        end else begin
          want = due_frame_bytes.pop_front();
          if (frame_byte_o !== want.data)
            flag_mismatch("frame_byte", int'(want.data), int'(frame_byte_o));
          if (byte_index_o !== want.index)
            flag_mismatch("byte_index", int'(want.index), int'(byte_index_o));
          if (last_byte_o !== want.last)
            flag_mismatch("last_byte", int'(want.last), int'(last_byte_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        n_pred = predict_frame_bytes(kind_i, rx_byte_i);
        if (typed_results != UNTYPED && typed_results != n_pred)
          flag_mismatch("result count", typed_results, n_pred);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_HEADER_VALUE) hdr_cfg = cfg_data_i;
        else if (cfg_index_i == CFG_MAX_LENGTH) max_cfg = cfg_data_i[3:0];
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[servo_reply_frame_receiver_unit] ERROR");
      $finish;
    end
  end

  // Offer one request after a random gap; hold it until it is taken.
  task automatic send_item(logic kind, logic [7:0] b, int typed);
    int gap;
    if (calm_in > 0) begin
      gap = 0;
      calm_in--;
    end else if ($urandom_range(0, 15) == 0) begin
      gap = 0;
      calm_in = 24;
    end else begin
      gap = $urandom_range(0, 6);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    rx_byte_i     <= b;
    typed_results <= typed;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_config(logic [7:0] hdr, logic [3:0] mlen);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_HEADER_VALUE;
    cfg_data_i  <= hdr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_MAX_LENGTH;
    cfg_data_i  <= {4'h0, mlen};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_hdr = hdr;
    cur_lim = (int'(mlen) > BufferBytesDef - 2) ? BufferBytesDef - 2 : int'(mlen);
  endtask

  // Drop valid, let every due byte come out, then give the pipeline time to empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_frame_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_traffic(int n_items);
    int         sent;
    int         pick;
    int         len;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_item(KIND_BYTE, cur_hdr, UNTYPED);
        send_item(KIND_BYTE, cur_hdr, UNTYPED);
        if (pick < 58 && cur_lim >= 2) len = $urandom_range(2, cur_lim);
        else if ($urandom_range(0, 2) == 0) len = $urandom_range(0, 1);
        else len = $urandom_range(cur_lim + 1, 255);
        send_item(KIND_BYTE, 8'(len), UNTYPED);
        sent += 3;
        if (len >= 2 && len <= cur_lim) begin
          repeat (len - 1) begin
            b = ($urandom_range(0, 7) == 0) ? cur_hdr : 8'($urandom_range(0, 255));
            send_item(KIND_BYTE, b, UNTYPED);
            sent++;
          end
          if ($urandom_range(0, 9) < 7) begin
            send_item(KIND_RELEASE, 8'($urandom_range(0, 255)), UNTYPED);
            sent++;
          end
        end
      end else if (pick < 80) begin
        // broken header pair
        send_item(KIND_BYTE, cur_hdr, UNTYPED);
        do b = 8'($urandom_range(0, 255)); while (b == cur_hdr);
        send_item(KIND_BYTE, b, UNTYPED);
        sent += 2;
      end else if (pick < 90) begin
        send_item(KIND_BYTE, 8'($urandom_range(0, 255)), UNTYPED);
        sent++;
      end else begin
        send_item(KIND_RELEASE, 8'($urandom_range(0, 255)), UNTYPED);
        sent++;
      end
    end
  endtask

  initial begin : byte_source
    logic [7:0] hdr;
    logic [3:0] mlen;
    int         n_items;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < N_ROWS; r++) begin
      send_item(directed_rows[r].kind, directed_rows[r].data, directed_rows[r].n_results);
    end
    settle();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin hdr = 8'h00; mlen = 4'd14; n_items = 80; end
        1: begin hdr = 8'hFF; mlen = 4'd2; n_items = 60; end
        2: begin
          hdr = 8'($urandom_range(0, 255));
          mlen = 4'($urandom_range(2, 14));
          n_items = 60;
        end
        3: begin hdr = 8'hA5; mlen = 4'd15; n_items = 60; end
        4: begin hdr = 8'h5A; mlen = 4'd1; n_items = 20; end
        default: begin
          hdr = 8'($urandom_range(0, 255));
          mlen = 4'($urandom_range(3, 12));
          n_items = 50;
        end
      endcase
      write_config(hdr, mlen);
      send_random_traffic(n_items);
      settle();
    end
    if (mismatch_count == 0 && due_frame_bytes.size() == 0) begin
      $display("[servo_reply_frame_receiver_unit] OK");
    end else begin
      $display("[servo_reply_frame_receiver_unit] ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    int calm_out;
    bit held;
    calm_out = 0;
    held     = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // hold off once for a long stretch so the block backs up into its input
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (calm_out > 0) begin
        stall = 0;
        calm_out--;
      end else if ($urandom_range(0, 15) == 0) begin
        stall = 0;
        calm_out = 30;
      end else begin
        stall = $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

endmodule
